[hw/rtl/shp_pkg.sv]
// shared types, constants and arithmetic for the 3x3 sharpen block
package shp_pkg;

    // frame limits and field widths
    localparam int MAX_WIDTH    = 2048;
    localparam int MAX_HEIGHT   = 4096;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT);
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CHAN_W       = 8;
    localparam int PIX_W        = 3 * CHAN_W;

    // register indexes of the configuration port
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    // item opcodes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [CHAN_W-1:0] in_red;
        logic [CHAN_W-1:0] in_green;
        logic [CHAN_W-1:0] in_blue;
    } t_in_item;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic              frame_last;
    } t_out_item;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_pix;

    // border position of the pixel under the kernel
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
        logic last;
    } t_edge_flags;

    // 5*centre minus four neighbours, clamped to 0..255
    function automatic logic [CHAN_W-1:0] sharpen_channel(
        input logic [CHAN_W-1:0] c,
        input logic [CHAN_W-1:0] u,
        input logic [CHAN_W-1:0] d,
        input logic [CHAN_W-1:0] l,
        input logic [CHAN_W-1:0] r
    );
        logic signed [11:0] acc;
        logic [CHAN_W-1:0]  res;
        acc = $signed({2'b00, c, 2'b00}) + $signed({4'b0000, c})
            - $signed({4'b0000, u}) - $signed({4'b0000, d})
            - $signed({4'b0000, l}) - $signed({4'b0000, r});
        if (acc < 12'sd0) begin
            res = '0;
        end else if (acc > 12'sd255) begin
            res = '1;
        end else begin
            res = acc[CHAN_W-1:0];
        end
        return res;
    endfunction

endpackage

[hw/rtl/shp_line_ram.sv]
// single port line store, read-first with registered read data
module shp_line_ram #(
    parameter int DEPTH  = 2048,
    parameter int DATA_W = 24,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // old contents come out while the new word goes in
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata        <= r_mem[i_addr];
            r_mem[i_addr]  <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/shp_cell.sv]
// one window cell: holds a pixel and hands it to its neighbor on each shift
module shp_cell (
    input  logic          i_clk,
    input  logic          i_shift,
    input  shp_pkg::t_pix i_pix,
    output shp_pkg::t_pix o_pix
);

    shp_pkg::t_pix r_pix;

    // take the upstream pixel on a shift, hold otherwise
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_pix <= i_pix;
        end
    end

    assign o_pix = r_pix;

endmodule

[hw/rtl/sharpen_3x3_replicate_border.sv]
// top level of the streaming 3x3 sharpen with replicated borders
//
// Input channel: one item per handshake, either a pixel of the frame in raster
// order or a drain tick. Output channel: one sharpened pixel per result item,
// in raster order, with frame_last set on the final pixel of the frame.
// Output pixel k is caused by the item that brings pixel k + width + 1; the
// rest are caused by the items after the last pixel. Drain ticks that arrive
// before the last pixel are taken and dropped. Throughput is one item per
// cycle when not stalled. Each item shifts a chain of window cells and two
// line stores (one read-first port each); results pass the window stage, then
// the output register. For a single-row frame the input stalls after the last
// pixel while the window shifts one padding step. When the receiver stalls,
// one finished item waits in the output register and one more in the window
// stage; the input then stalls too. Reset (synchronous, active low) sets
// width 640, height 480 and starts a new frame. Writing either register also
// starts a new frame; write only when idle. Line store contents are not
// cleared and need no clearing pass.
module sharpen_3x3_replicate_border (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_index,
    input  logic [shp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  shp_pkg::t_in_item                i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output shp_pkg::t_out_item               o_out_item
);

    localparam int COL_W = shp_pkg::COL_W;
    localparam int ROW_W = shp_pkg::ROW_W;
    localparam int WR_W  = shp_pkg::WIDTH_REG_W;
    localparam int HR_W  = shp_pkg::HEIGHT_REG_W;

    // configuration registers
    logic [WR_W-1:0] r_width;
    logic [HR_W-1:0] r_height;

    // frame position state
    logic [COL_W-1:0] r_vcol, n_vcol;
    logic [COL_W-1:0] r_prev_col, n_prev_col;
    logic [ROW_W-1:0] r_in_row, n_in_row;
    logic             r_in_done, n_in_done;
    logic [WR_W-1:0]  r_fill, n_fill;
    logic             r_pad, n_pad;
    logic [COL_W-1:0] r_out_col, n_out_col;
    logic [ROW_W-1:0] r_out_row, n_out_row;

    // pipeline state
    logic                   r_s1_vld;
    shp_pkg::t_edge_flags   r_s1_flags;
    logic                   r_out_vld;
    shp_pkg::t_out_item     r_out;

    logic [WR_W-1:0]  w_eff;
    logic [HR_W-1:0]  h_eff;
    logic [COL_W-1:0] w_m1;
    logic [ROW_W-1:0] h_m1;
    logic [WR_W-1:0]  w_p1;
    logic             fill_full;
    logic             in_acc, is_pix, shift_in, pad_go, shift, emit, last_px;
    logic             s1_move, s1_free, restart;
    logic             col_wrap;
    shp_pkg::t_edge_flags flags;

    shp_pkg::t_pix    px_new, cell_new_q, cell_down_q, cell_mid_q, cell_left_q;
    shp_pkg::t_pix    ram_right_q, ram_up_q;
    shp_pkg::t_pix    nb_up, nb_down, nb_left, nb_right;
    shp_pkg::t_out_item res;

    // effective frame size: zero counts as one, large values saturate
    always_comb begin
        if (r_width == '0) begin
            w_eff = WR_W'(1);
        end else if (r_width > WR_W'(shp_pkg::MAX_WIDTH)) begin
            w_eff = WR_W'(shp_pkg::MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        if (r_height == '0) begin
            h_eff = HR_W'(1);
        end else if (r_height > HR_W'(shp_pkg::MAX_HEIGHT)) begin
            h_eff = HR_W'(shp_pkg::MAX_HEIGHT);
        end else begin
            h_eff = r_height;
        end
    end

    assign w_m1      = COL_W'(w_eff - WR_W'(1));
    assign h_m1      = ROW_W'(h_eff - HR_W'(1));
    assign w_p1      = w_eff + WR_W'(1);
    assign fill_full = (r_fill == w_p1);

    // handshake and step control
    assign s1_move    = r_s1_vld && (!r_out_vld || i_out_ready);
    assign s1_free    = !r_s1_vld || s1_move;
    assign o_in_ready = s1_free && !r_pad;
    assign in_acc     = i_in_valid && o_in_ready;
    assign is_pix     = (i_in_item.opcode == shp_pkg::OP_PIXEL);
    assign shift_in   = in_acc && (r_in_done || is_pix);
    assign pad_go     = r_pad && s1_free;
    assign shift      = shift_in || pad_go;
    assign emit       = shift_in && (r_in_done || fill_full);
    assign col_wrap   = (r_vcol == w_m1);
    assign last_px    = shift_in && !r_in_done && col_wrap && (r_in_row == h_m1);

    // border position of the next output pixel
    always_comb begin
        flags.top    = (r_out_row == '0);
        flags.bottom = (r_out_row == h_m1);
        flags.left   = (r_out_col == '0);
        flags.right  = (r_out_col == w_m1);
        flags.last   = flags.bottom && flags.right;
    end

    assign restart = (emit && flags.last) || i_cfg_we;

    // next values of the position counters
    always_comb begin
        n_vcol     = r_vcol;
        n_prev_col = r_prev_col;
        n_in_row   = r_in_row;
        n_in_done  = r_in_done;
        n_fill     = r_fill;
        n_pad      = r_pad;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        if (shift) begin
            n_prev_col = r_vcol;
            n_vcol     = col_wrap ? '0 : r_vcol + COL_W'(1);
            if (!fill_full) begin
                n_fill = r_fill + WR_W'(1);
            end
        end
        if (shift_in && !r_in_done && col_wrap) begin
            n_in_row = r_in_row + ROW_W'(1);
        end
        if (last_px) begin
            n_in_done = 1'b1;
            n_pad     = (h_eff == HR_W'(1));
        end
        if (pad_go) begin
            n_pad = 1'b0;
        end
        if (emit) begin
            if (flags.right) begin
                n_out_col = '0;
                n_out_row = r_out_row + ROW_W'(1);
            end else begin
                n_out_col = r_out_col + COL_W'(1);
            end
        end
        if (restart) begin
            n_vcol     = '0;
            n_prev_col = '0;
            n_in_row   = '0;
            n_in_done  = 1'b0;
            n_fill     = '0;
            n_pad      = 1'b0;
            n_out_col  = '0;
            n_out_row  = '0;
        end
    end

    // control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= WR_W'(640);
            r_height   <= HR_W'(480);
            r_vcol     <= '0;
            r_prev_col <= '0;
            r_in_row   <= '0;
            r_in_done  <= 1'b0;
            r_fill     <= '0;
            r_pad      <= 1'b0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_s1_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == shp_pkg::CFG_IMAGE_WIDTH) begin
                r_width <= i_cfg_data[WR_W-1:0];
            end
            if (i_cfg_we && i_cfg_index == shp_pkg::CFG_IMAGE_HEIGHT) begin
                r_height <= i_cfg_data[HR_W-1:0];
            end
            r_vcol     <= n_vcol;
            r_prev_col <= n_prev_col;
            r_in_row   <= n_in_row;
            r_in_done  <= n_in_done;
            r_fill     <= n_fill;
            r_pad      <= n_pad;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            if (emit) begin
                r_s1_vld <= 1'b1;
            end else if (s1_move) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_move) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // incoming pixel, drain ticks shift in don't-care data
    always_comb begin
        px_new.red   = i_in_item.in_red;
        px_new.green = i_in_item.in_green;
        px_new.blue  = i_in_item.in_blue;
    end

    // window chain: newest pixel, then the pixel below the centre
    shp_cell u_cell_new (
        .i_clk   (i_clk),
        .i_shift (shift),
        .i_pix   (px_new),
        .o_pix   (cell_new_q)
    );

    shp_cell u_cell_down (
        .i_clk   (i_clk),
        .i_shift (shift),
        .i_pix   (cell_new_q),
        .o_pix   (cell_down_q)
    );

    // first line store: one row back, gives the right neighbor
    shp_line_ram #(
        .DEPTH  (shp_pkg::MAX_WIDTH),
        .DATA_W (shp_pkg::PIX_W)
    ) u_line_mid (
        .i_clk   (i_clk),
        .i_en    (shift),
        .i_addr  (r_vcol),
        .i_wdata (px_new),
        .o_rdata (ram_right_q)
    );

    // centre and left neighbor follow the first line store
    shp_cell u_cell_mid (
        .i_clk   (i_clk),
        .i_shift (shift),
        .i_pix   (ram_right_q),
        .o_pix   (cell_mid_q)
    );

    shp_cell u_cell_left (
        .i_clk   (i_clk),
        .i_shift (shift),
        .i_pix   (cell_mid_q),
        .o_pix   (cell_left_q)
    );

    // second line store: one more row back, gives the upper neighbor
    shp_line_ram #(
        .DEPTH  (shp_pkg::MAX_WIDTH),
        .DATA_W (shp_pkg::PIX_W)
    ) u_line_up (
        .i_clk   (i_clk),
        .i_en    (shift),
        .i_addr  (r_prev_col),
        .i_wdata (ram_right_q),
        .o_rdata (ram_up_q)
    );

    // replicate the centre where a neighbor lies outside the frame
    assign nb_up    = r_s1_flags.top    ? cell_mid_q : ram_up_q;
    assign nb_down  = r_s1_flags.bottom ? cell_mid_q : cell_down_q;
    assign nb_left  = r_s1_flags.left   ? cell_mid_q : cell_left_q;
    assign nb_right = r_s1_flags.right  ? cell_mid_q : ram_right_q;

    // per channel kernel
    always_comb begin
        res.out_red    = shp_pkg::sharpen_channel(cell_mid_q.red, nb_up.red,
                             nb_down.red, nb_left.red, nb_right.red);
        res.out_green  = shp_pkg::sharpen_channel(cell_mid_q.green, nb_up.green,
                             nb_down.green, nb_left.green, nb_right.green);
        res.out_blue   = shp_pkg::sharpen_channel(cell_mid_q.blue, nb_up.blue,
                             nb_down.blue, nb_left.blue, nb_right.blue);
        res.frame_last = r_s1_flags.last;
    end

    // border flags ride with the window, result goes to the output register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_s1_flags <= flags;
        end
        if (s1_move) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    // the window holds still while its result waits for the output register
    a_window_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !s1_move) |=> ($stable(cell_mid_q) && $stable(r_s1_flags)))
        else $error("window changed under a waiting result");

    // once all pixels are in, the window is primed unless padding is pending
    a_primed_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_done && !r_pad) |-> fill_full)
        else $error("drain started with an unprimed window");

    // outputs never run ahead of the input rows
    a_out_behind_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_done |-> (r_out_row <= r_in_row))
        else $error("output row ahead of input row");

    // a padding step never coincides with an accepted item
    a_pad_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pad_go |-> !shift_in)
        else $error("padding step overlapped an item");
`endif

endmodule

[test/sharpen_3x3_replicate_border_test.sv]
// self-checking testbench for the streaming 3x3 sharpen with replicated borders
module sharpen_3x3_replicate_border_test;
    import shp_pkg::*;

    // kinds of pixel content used for random frames
    typedef enum int unsigned {
        TEX_NOISE,
        TEX_BINARY,
        TEX_FLAT
    } t_texture;

    localparam int unsigned RING_SLOTS = 2 * MAX_WIDTH + 2;

    // clock, reset and block ports
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic                  cfg_index = 1'b0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_item   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_item;

    // predictor state: registers, pixel history and raster positions
    logic [WIDTH_REG_W-1:0]  width_reg  = 12'd640;
    logic [HEIGHT_REG_W-1:0] height_reg = 13'd480;
    t_pix                    pixel_ring [RING_SLOTS];
    int unsigned             in_row  = 0;
    int unsigned             in_col  = 0;
    int unsigned             out_row = 0;
    int unsigned             out_col = 0;

    // items waiting to be sent and sharpened pixels waiting to arrive
    t_in_item  pending_px [$];
    t_out_item sharpened_q [$];

    // bookkeeping
    int unsigned issued_cnt   = 0;
    int unsigned accepted_cnt = 0;
    int unsigned checked_cnt  = 0;
    int unsigned frames_seen  = 0;
    int unsigned err_cnt      = 0;
    int unsigned send_gap     = 0;
    int unsigned recv_stall   = 0;
    bit          send_steady  = 1'b0;
    bit          recv_steady  = 1'b0;

    sharpen_3x3_replicate_border u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    // clock
    initial begin
        forever #4 clk = ~clk;
    end

    // effective frame size after range fixing
    function automatic int unsigned active_width();
        int unsigned w;
        w = 32'(width_reg);
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned active_height();
        int unsigned h;
        h = 32'(height_reg);
        if (h == 0) h = 1;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return h;
    endfunction

    function automatic void restart_frame();
        in_row  = 0;
        in_col  = 0;
        out_row = 0;
        out_col = 0;
    endfunction

    // 5*centre minus the four neighbours, clipped to a byte
    function automatic logic [CHAN_W-1:0] clip_sharpen(
        logic [CHAN_W-1:0] c,
        logic [CHAN_W-1:0] u,
        logic [CHAN_W-1:0] d,
        logic [CHAN_W-1:0] l,
        logic [CHAN_W-1:0] r
    );
        int sum;
        sum = 5 * int'(c) - int'(u) - int'(d) - int'(l) - int'(r);
        if (sum < 0) sum = 0;
        if (sum > 255) sum = 255;
        return sum[CHAN_W-1:0];
    endfunction

    // sharpen the next output position and queue it as expected
    function automatic void emit_sharpened(int unsigned w, int unsigned h);
        int unsigned depth, r, c, ru, rd, cl, cr;
        t_pix        ce, up, dn, lf, rt;
        t_out_item   res;
        depth = 2 * w + 2;
        r  = out_row;
        c  = out_col;
        ru = (r > 0) ? r - 1 : r;
        rd = (r + 1 < h) ? r + 1 : r;
        cl = (c > 0) ? c - 1 : c;
        cr = (c + 1 < w) ? c + 1 : c;
        ce = pixel_ring[(r * w + c) % depth];
        up = pixel_ring[(ru * w + c) % depth];
        dn = pixel_ring[(rd * w + c) % depth];
        lf = pixel_ring[(r * w + cl) % depth];
        rt = pixel_ring[(r * w + cr) % depth];
        res.out_red   = clip_sharpen(ce.red, up.red, dn.red, lf.red, rt.red);
        res.out_green = clip_sharpen(ce.green, up.green, dn.green, lf.green, rt.green);
        res.out_blue  = clip_sharpen(ce.blue, up.blue, dn.blue, lf.blue, rt.blue);
        if (r + 1 >= h && c + 1 >= w) begin
            res.frame_last = 1'b1;
            restart_frame();
        end else begin
            res.frame_last = 1'b0;
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
        sharpened_q.push_back(res);
    endfunction

    // advance the predictor by one accepted item
    function automatic void predict_item(t_in_item it);
        int unsigned w, h, p, k;
        w = active_width();
        h = active_height();
        // once the frame is complete every item drains one output
        if (in_row >= h) begin
            emit_sharpened(w, h);
            return;
        end
        // drain tick in the middle of a frame is dropped
        if (it.opcode == OP_DRAIN) return;
        p = in_row * w + in_col;
        pixel_ring[p % (2 * w + 2)] = {it.in_red, it.in_green, it.in_blue};
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        k = out_row * w + out_col;
        if (p >= k + w + 1) emit_sharpened(w, h);
    endfunction

    task automatic report_mismatch(string msg);
        err_cnt++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [CHAN_W-1:0] got, logic [CHAN_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("pixel %0d %s: got %0h, want %0h",
                                      checked_cnt, name, got, want));
        end
    endtask

    // idle length: mostly short, a few long, none in steady stretches
    function automatic int unsigned pick_gap(bit steady);
        int unsigned roll;
        if (steady) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // input driver: sends queued items, predicts on every accepted one
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                predict_item(in_item);
                accepted_cnt++;
                if ($urandom_range(0, 255) == 0) send_steady = !send_steady;
            end
            if (!in_valid || in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (pending_px.size() > 0) begin
                    in_item  <= pending_px.pop_front();
                    in_valid <= 1'b1;
                    send_gap = pick_gap(send_steady);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor: random back-pressure, compares against oldest expectation
    always @(posedge clk) begin
        t_out_item want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (sharpened_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected pixel %0h", out_item));
                end else begin
                    want = sharpened_q.pop_front();
                    check_field("red", out_item.out_red, want.out_red);
                    check_field("green", out_item.out_green, want.out_green);
                    check_field("blue", out_item.out_blue, want.out_blue);
                    check_field("frame_last", {7'd0, out_item.frame_last},
                                {7'd0, want.frame_last});
                    if (want.frame_last) frames_seen++;
                end
                checked_cnt++;
                if ($urandom_range(0, 255) == 0) recv_steady = !recv_steady;
            end
            if (recv_stall > 0) begin
                recv_stall--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                recv_stall = pick_gap(recv_steady);
            end
        end
    end

    function automatic void push_item(t_in_item it);
        pending_px.push_back(it);
        issued_cnt++;
    endfunction

    function automatic logic [CHAN_W-1:0] pick_chan(t_texture tex, logic [CHAN_W-1:0] base);
        int v;
        case (tex)
            TEX_BINARY: begin
                v = ($urandom_range(0, 1) == 1) ? 255 : 0;
            end
            TEX_FLAT: begin
                v = int'(base) + int'($urandom_range(0, 24)) - 12;
            end
            default: begin
                v = $urandom_range(0, 255);
            end
        endcase
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[CHAN_W-1:0];
    endfunction

    function automatic t_in_item make_item(logic op, t_texture tex, logic [CHAN_W-1:0] base);
        t_in_item it;
        it.opcode   = op;
        it.in_red   = pick_chan(tex, base);
        it.in_green = pick_chan(tex, base);
        it.in_blue  = pick_chan(tex, base);
        return it;
    endfunction

    // queue one frame at the current size; a nonzero cut stops after that many pixels
    function automatic int unsigned queue_frame(t_texture tex, int unsigned cut);
        int unsigned      w, h, npix, nterm, i;
        logic [CHAN_W-1:0] base;
        w     = active_width();
        h     = active_height();
        npix  = (cut != 0) ? cut : w * h;
        nterm = (cut != 0) ? 0 : ((w * h < w + 1) ? w * h : w + 1);
        base  = CHAN_W'($urandom_range(0, 255));
        for (i = 0; i < npix; i++) begin
            // stray drain tick inside the frame
            if ($urandom_range(0, 31) == 0) push_item(make_item(OP_DRAIN, TEX_NOISE, base));
            push_item(make_item(OP_PIXEL, tex, base));
        end
        // tail: mostly drain ticks, some late pixels that act as drains
        for (i = 0; i < nterm; i++) begin
            if ($urandom_range(0, 4) == 0) push_item(make_item(OP_PIXEL, TEX_NOISE, base));
            else push_item(make_item(OP_DRAIN, TEX_NOISE, base));
        end
        if (cut == 0 && $urandom_range(0, 7) == 0) push_item(make_item(OP_DRAIN, tex, base));
        return npix + nterm;
    endfunction

    task automatic write_reg(logic idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_IMAGE_WIDTH) width_reg = value[WIDTH_REG_W-1:0];
        else height_reg = value;
        restart_frame();
    endtask

    // wait until everything sent is accepted and every expected pixel is back
    task automatic settle();
        int unsigned guard;
        guard = 0;
        while (accepted_cnt != issued_cnt) @(posedge clk);
        while (sharpened_q.size() != 0 && guard < 4000) begin
            @(posedge clk);
            guard++;
        end
        repeat (16) @(posedge clk);
        if (sharpened_q.size() != 0) begin
            report_mismatch($sformatf("%0d sharpened pixels never arrived",
                                      sharpened_q.size()));
            sharpened_q.delete();
        end
    endtask

    // stimulus: directed frames, size extremes, then random frames
    initial begin
        int unsigned             random_cnt;
        int unsigned             nframes, f, cut;
        logic [WIDTH_REG_W-1:0]  wv;
        logic [HEIGHT_REG_W-1:0] hv;
        random_cnt = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // 2x2 frame with saturating contrast, a stray drain and a late pixel
        write_reg(CFG_IMAGE_WIDTH, 13'd2);
        write_reg(CFG_IMAGE_HEIGHT, 13'd2);
        push_item(t_in_item'{OP_PIXEL, 8'hff, 8'h00, 8'h80});
        push_item(t_in_item'{OP_DRAIN, 8'h5a, 8'ha5, 8'h3c});
        push_item(t_in_item'{OP_PIXEL, 8'h00, 8'hff, 8'h80});
        push_item(t_in_item'{OP_PIXEL, 8'h00, 8'hff, 8'h7f});
        push_item(t_in_item'{OP_PIXEL, 8'hff, 8'h00, 8'h01});
        push_item(t_in_item'{OP_DRAIN, 8'h00, 8'h00, 8'h00});
        push_item(t_in_item'{OP_PIXEL, 8'haa, 8'h55, 8'haa});
        push_item(t_in_item'{OP_DRAIN, 8'hff, 8'hff, 8'hff});
        push_item(t_in_item'{OP_DRAIN, 8'h12, 8'h34, 8'h56});
        settle();

        // zero sizes fall back to a single pixel
        write_reg(CFG_IMAGE_WIDTH, 13'd0);
        write_reg(CFG_IMAGE_HEIGHT, 13'd0);
        push_item(t_in_item'{OP_PIXEL, 8'hff, 8'hff, 8'hff});
        push_item(t_in_item'{OP_DRAIN, 8'h00, 8'h00, 8'h00});
        push_item(t_in_item'{OP_PIXEL, 8'h00, 8'h00, 8'h00});
        push_item(t_in_item'{OP_PIXEL, 8'h80, 8'h7f, 8'h01});
        settle();

        // abandoned partial frame, then a register write restarts it
        write_reg(CFG_IMAGE_WIDTH, 13'd3);
        write_reg(CFG_IMAGE_HEIGHT, 13'd3);
        push_item(t_in_item'{OP_PIXEL, 8'hff, 8'hff, 8'hff});
        push_item(t_in_item'{OP_PIXEL, 8'hff, 8'hff, 8'hff});
        settle();
        write_reg(CFG_IMAGE_HEIGHT, 13'd2);
        void'(queue_frame(TEX_BINARY, 0));
        settle();

        // saturating width, a partial frame too short to reach any output
        write_reg(CFG_IMAGE_WIDTH, 13'h1fff);
        write_reg(CFG_IMAGE_HEIGHT, 13'd2);
        void'(queue_frame(TEX_NOISE, 200));
        settle();

        // saturating height, one column, partial frame
        write_reg(CFG_IMAGE_HEIGHT, 13'h1fff);
        write_reg(CFG_IMAGE_WIDTH, 13'd1);
        void'(queue_frame(TEX_FLAT, 300));
        settle();

        // random frame sizes, mostly small
        while (random_cnt < 1350) begin
            wv = ($urandom_range(0, 7) == 0) ? WIDTH_REG_W'($urandom_range(13, 80))
                                             : WIDTH_REG_W'($urandom_range(1, 12));
            hv = ($urandom_range(0, 7) == 0) ? HEIGHT_REG_W'($urandom_range(7, 20))
                                             : HEIGHT_REG_W'($urandom_range(1, 6));
            if ($urandom_range(0, 15) == 0) wv = '0;
            if ($urandom_range(0, 15) == 0) hv = '0;
            if ($urandom_range(0, 1) == 1) begin
                write_reg(CFG_IMAGE_WIDTH, {$urandom_range(0, 1) == 1, wv});
                write_reg(CFG_IMAGE_HEIGHT, hv);
            end else begin
                write_reg(CFG_IMAGE_HEIGHT, hv);
                write_reg(CFG_IMAGE_WIDTH, {$urandom_range(0, 1) == 1, wv});
            end
            nframes = $urandom_range(1, 3);
            for (f = 0; f < nframes; f++) begin
                // sometimes the last frame of a phase is cut short
                cut = 0;
                if (f == nframes - 1 && $urandom_range(0, 9) == 0) begin
                    cut = $urandom_range(1, active_width() * active_height());
                end
                random_cnt += queue_frame(t_texture'($urandom_range(0, 2)), cut);
            end
            settle();
        end

        $display("run covered %0d items accepted, %0d sharpened pixels checked",
                 accepted_cnt, checked_cnt);
        $display("%0d complete frames up to 80x20, plus partial frames at saturated sizes",
                 frames_seen);
        if (err_cnt == 0) begin
            $display("sharpen_3x3_replicate_border_test: clean");
        end else begin
            $display("sharpen_3x3_replicate_border_test: errors");
        end
        $finish;
    end

    // hang guard
    initial begin
        #32_000_000;
        $display("timeout with %0d items accepted of %0d", accepted_cnt, issued_cnt);
        $display("sharpen_3x3_replicate_border_test: errors");
        $finish;
    end

endmodule

[files.f]
hw/rtl/shp_pkg.sv
hw/rtl/shp_line_ram.sv
hw/rtl/shp_cell.sv
hw/rtl/sharpen_3x3_replicate_border.sv
test/sharpen_3x3_replicate_border_test.sv
